### src/fwds_pkg.sv
package fwds_pkg;

   // Package size in bytes and the saturation limits of the 24-bit and 6-bit counters.
   localparam int unsigned PACKAGE_BYTES = 128;
   localparam logic [23:0] MAX_24        = 24'hFF_FFFF;
   localparam logic [5:0]  MAX_CONNECT   = 6'd63;

   // Event kinds on the request channel.
   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_START   = 2'd1,
      MODE_CONNECT = 2'd2,
      MODE_ACK     = 2'd3
   } mode_type;

   // Actions on the response channel.
   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_CONNECT  = 3'd1,
      ACT_PACKAGE  = 3'd2,
      ACT_RUN      = 3'd3,
      ACT_TIMEOUT  = 3'd4
   } action_type;

   // Recorded session status.
   typedef enum logic [1:0] {
      STATUS_NONE  = 2'd0,
      STATUS_BUSY  = 2'd1,
      STATUS_DONE  = 2'd2
   } status_type;

   // Download phases.
   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_CONNECT   = 2'd1,
      PH_SEND      = 2'd2,
      PH_FINISH    = 2'd3
   } phase_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_IMAGE_SIZE     = 3'd0;
   localparam logic [2:0] CSR_CONNECT_PERIOD = 3'd1;
   localparam logic [2:0] CSR_RESEND_PERIOD  = 3'd2;
   localparam logic [2:0] CSR_RUN_PERIOD     = 3'd3;
   localparam logic [2:0] CSR_CONNECT_LIMIT  = 3'd4;
   localparam logic [2:0] CSR_RETRY_LIMIT    = 3'd5;

   // Reset values of the configuration registers.
   localparam logic [23:0] RST_IMAGE_SIZE     = 24'd0;
   localparam logic [23:0] RST_CONNECT_PERIOD = 24'd100;
   localparam logic [23:0] RST_RESEND_PERIOD  = 24'd1000000;
   localparam logic [23:0] RST_RUN_PERIOD     = 24'd2000000;
   localparam logic [5:0]  RST_CONNECT_LIMIT  = 6'd30;
   localparam logic [3:0]  RST_RETRY_LIMIT    = 4'd3;

   // Current configuration as seen by the sequencing engine.
   typedef struct packed {
      logic [23:0] image_size;
      logic [23:0] connect_period;
      logic [23:0] resend_period;
      logic [23:0] run_period;
      logic [5:0]  connect_limit;
      logic [3:0]  retry_limit;
   } config_type;

   // One response transaction.
   typedef struct packed {
      action_type  action;
      logic [15:0] package_number;
      logic [23:0] flash_offset;
      logic        busy_res;
      status_type  progress;
      logic        save_record;
   } result_type;

endpackage

### src/fwds_csr.sv
module fwds_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [23:0]         csr_write_data,
   output fwds_pkg::config_type cfg
);

   fwds_pkg::config_type cfg_ff;
   fwds_pkg::config_type cfg_in;

   // Decode the write; indexes beyond the register list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            fwds_pkg::CSR_IMAGE_SIZE:     cfg_in.image_size     = csr_write_data;
            fwds_pkg::CSR_CONNECT_PERIOD: cfg_in.connect_period = csr_write_data;
            fwds_pkg::CSR_RESEND_PERIOD:  cfg_in.resend_period  = csr_write_data;
            fwds_pkg::CSR_RUN_PERIOD:     cfg_in.run_period     = csr_write_data;
            fwds_pkg::CSR_CONNECT_LIMIT:  cfg_in.connect_limit  = csr_write_data[5:0];
            fwds_pkg::CSR_RETRY_LIMIT:    cfg_in.retry_limit    = csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_size     <= fwds_pkg::RST_IMAGE_SIZE;
         cfg_ff.connect_period <= fwds_pkg::RST_CONNECT_PERIOD;
         cfg_ff.resend_period  <= fwds_pkg::RST_RESEND_PERIOD;
         cfg_ff.run_period     <= fwds_pkg::RST_RUN_PERIOD;
         cfg_ff.connect_limit  <= fwds_pkg::RST_CONNECT_LIMIT;
         cfg_ff.retry_limit    <= fwds_pkg::RST_RETRY_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/fwds_engine.sv
module fwds_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  fwds_pkg::mode_type   mode,
   input  logic                 reply_ok,
   input  fwds_pkg::config_type cfg,
   output fwds_pkg::result_type result
);

   fwds_pkg::phase_type  phase_ff, phase_in;
   fwds_pkg::status_type status_ff, status_in;
   logic                 active_ff, active_in;
   logic [5:0]           connect_count_ff, connect_count_in;
   logic [3:0]           retry_count_ff, retry_count_in;
   logic [23:0]          elapsed_ff, elapsed_in;
   logic [15:0]          package_ff, package_in;
   logic [23:0]          offset_ff, offset_in;

   logic [23:0]          period;
   logic [23:0]          elapsed_inc;
   logic                 fires;
   logic [6:0]           connect_next;
   logic [24:0]          offset_sum;
   logic [23:0]          offset_adv;
   logic                 retry_left;
   logic                 pkg;

   // Session timer: saturating increment, fire when the phase period is reached.
   always_comb begin
      case (phase_ff)
         fwds_pkg::PH_CONNECT: period = cfg.connect_period;
         fwds_pkg::PH_SEND:    period = cfg.resend_period;
         default:              period = cfg.run_period;
      endcase
      elapsed_inc = (elapsed_ff != fwds_pkg::MAX_24) ? elapsed_ff + 24'd1 : elapsed_ff;
      fires       = (elapsed_inc >= period);
   end

   // Saturating offset advance and attempt counter.
   always_comb begin
      offset_sum   = {1'b0, offset_ff} + 25'(fwds_pkg::PACKAGE_BYTES);
      offset_adv   = offset_sum[24] ? fwds_pkg::MAX_24 : offset_sum[23:0];
      connect_next = {1'b0, connect_count_ff} + 7'd1;
      retry_left   = (retry_count_ff < cfg.retry_limit);
   end

   // Next state and result for the event in the input stage.
   always_comb begin
      phase_in         = phase_ff;
      status_in        = status_ff;
      active_in        = active_ff;
      connect_count_in = connect_count_ff;
      retry_count_in   = retry_count_ff;
      elapsed_in       = elapsed_ff;
      package_in       = package_ff;
      offset_in        = offset_ff;
      pkg              = 1'b0;
      result.action      = fwds_pkg::ACT_NONE;
      result.save_record = 1'b0;

      case (mode)
         fwds_pkg::MODE_TICK: begin
            if (phase_ff != fwds_pkg::PH_IDLE) begin
               elapsed_in = fires ? 24'd0 : elapsed_inc;
            end
            case (phase_ff)
               fwds_pkg::PH_CONNECT: begin
                  if (fires) begin
                     connect_count_in = connect_next[6] ? fwds_pkg::MAX_CONNECT
                                                        : connect_next[5:0];
                     if (connect_next > {1'b0, cfg.connect_limit}) begin
                        result.action      = fwds_pkg::ACT_TIMEOUT;
                        phase_in           = fwds_pkg::PH_IDLE;
                        active_in          = 1'b0;
                        status_in          = fwds_pkg::STATUS_NONE;
                        result.save_record = 1'b1;
                     end else begin
                        result.action = fwds_pkg::ACT_CONNECT;
                     end
                  end
               end
               fwds_pkg::PH_SEND: begin
                  if (fires && retry_left) begin
                     result.action  = fwds_pkg::ACT_PACKAGE;
                     pkg            = 1'b1;
                     retry_count_in = retry_count_ff + 4'd1;
                  end
               end
               fwds_pkg::PH_FINISH: begin
                  if (fires && retry_left) begin
                     result.action  = fwds_pkg::ACT_RUN;
                     retry_count_in = retry_count_ff + 4'd1;
                  end
               end
               default: ;
            endcase
         end
         fwds_pkg::MODE_START: begin
            phase_in           = fwds_pkg::PH_CONNECT;
            active_in          = 1'b1;
            connect_count_in   = 6'd0;
            elapsed_in         = 24'd0;
            status_in          = fwds_pkg::STATUS_NONE;
            result.save_record = 1'b1;
         end
         fwds_pkg::MODE_CONNECT: begin
            if (phase_ff == fwds_pkg::PH_CONNECT && reply_ok) begin
               status_in          = fwds_pkg::STATUS_BUSY;
               result.save_record = 1'b1;
               phase_in           = fwds_pkg::PH_SEND;
               offset_in          = 24'd0;
               package_in         = 16'd1;
               result.action      = fwds_pkg::ACT_PACKAGE;
               pkg                = 1'b1;
               elapsed_in         = 24'd0;
               retry_count_in     = 4'd0;
            end
         end
         default: begin
            // Package acknowledge, acted on only while sending.
            if (phase_ff == fwds_pkg::PH_SEND) begin
               if (reply_ok) begin
                  offset_in  = offset_adv;
                  package_in = package_ff + 16'd1;
               end
               elapsed_in     = 24'd0;
               retry_count_in = 4'd0;
               if (offset_in < cfg.image_size) begin
                  result.action = fwds_pkg::ACT_PACKAGE;
                  pkg           = 1'b1;
               end else begin
                  status_in          = fwds_pkg::STATUS_DONE;
                  result.save_record = 1'b1;
                  result.action      = fwds_pkg::ACT_RUN;
                  phase_in           = fwds_pkg::PH_FINISH;
               end
            end
         end
      endcase

      result.package_number = pkg ? package_in : 16'd0;
      result.flash_offset   = pkg ? offset_in : 24'd0;
      result.busy_res       = active_in;
      result.progress       = status_in;
   end

   // Session state advances once per event.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= fwds_pkg::PH_IDLE;
         status_ff        <= fwds_pkg::STATUS_NONE;
         active_ff        <= 1'b0;
         connect_count_ff <= 6'd0;
         retry_count_ff   <= 4'd0;
         elapsed_ff       <= 24'd0;
         package_ff       <= 16'd0;
         offset_ff        <= 24'd0;
      end else if (step) begin
         phase_ff         <= phase_in;
         status_ff        <= status_in;
         active_ff        <= active_in;
         connect_count_ff <= connect_count_in;
         retry_count_ff   <= retry_count_in;
         elapsed_ff       <= elapsed_in;
         package_ff       <= package_in;
         offset_ff        <= offset_in;
      end
   end

endmodule

### src/firmware_download_sequencer_core.sv
// Firmware download sequencer.
// Request channel (req_valid, req_stall, req_mode, req_reply_ok) carries one
// event per transaction: tick, start, connect reply or package acknowledge.
// Response channel (rsp_valid, rsp_stall and the rsp_ payload) returns exactly
// one action per event, in order.
// Configuration is written through csr_write_enable, csr_index and csr_write_data;
// the user must write it only while no transaction is in flight, which the block
// does not enforce; unknown indexes are dropped. An accepted event is registered
// in the input stage, processed against the session state and presented on the
// response port from the result register. Throughput: one event per cycle unless
// the receiver stalls; the session state update is a single pass of compares and
// increments between the input stage and the result register.
// When the receiver stalls, the result register holds its transaction and the
// input stage holds one more; req_stall rises only when both are full.
// Synchronous reset empties both stages, puts the session into the idle phase
// and loads the configuration registers with their default values.
module firmware_download_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic        req_reply_ok,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic [15:0] rsp_package_number,
   output logic [23:0] rsp_flash_offset,
   output logic        rsp_busy_res,
   output logic [1:0]  rsp_progress,
   output logic        rsp_save_record,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_write_data
);

   fwds_pkg::config_type cfg;
   fwds_pkg::result_type result;
   fwds_pkg::result_type rsp_ff;
   fwds_pkg::mode_type   mode_ff;
   logic                 reply_ok_ff;
   logic                 in_valid_ff;
   logic                 rsp_valid_ff;
   logic                 advance;
   logic                 req_take;

   fwds_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   fwds_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .mode     (mode_ff),
      .reply_ok (reply_ok_ff),
      .cfg      (cfg),
      .result   (result)
   );

   // The input stage moves on when the result register is empty or being taken.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff     <= fwds_pkg::mode_type'(req_mode);
         reply_ok_ff <= req_reply_ok;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = rsp_ff.action;
   assign rsp_package_number = rsp_ff.package_number;
   assign rsp_flash_offset   = rsp_ff.flash_offset;
   assign rsp_busy_res       = rsp_ff.busy_res;
   assign rsp_progress       = rsp_ff.progress;
   assign rsp_save_record    = rsp_ff.save_record;

   // Back pressure reaches the requester only when both stages are occupied.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while a stage was free");

   // Package fields are zero unless a package is sent.
   a_pkg_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action != fwds_pkg::ACT_PACKAGE) |->
         (rsp_package_number == 16'd0 && rsp_flash_offset == 24'd0))
      else $error("package fields set without a package action");

   // A connect timeout closes the session and saves the cleared record.
   a_timeout: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == fwds_pkg::ACT_TIMEOUT) |->
         (!rsp_busy_res && rsp_save_record && rsp_progress == fwds_pkg::STATUS_NONE))
      else $error("connect timeout left the session open");

   // The first run command of a session records the finished download.
   a_run_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == fwds_pkg::ACT_RUN && rsp_save_record) |->
         (rsp_progress == fwds_pkg::STATUS_DONE && rsp_busy_res))
      else $error("run command saved without done status");

endmodule
